/* rtl/icd_pkg.sv */
// Shared types, codes and byte constants for the charset detector.
`timescale 1ns / 1ps
`default_nettype none

package icd_pkg;

  typedef enum logic [2:0] {
    CODE_NOTSET = 3'd0,
    CODE_AUTO   = 3'd1,
    CODE_CN     = 3'd2,
    CODE_JP     = 3'd3,
    CODE_KR     = 3'd4,
    CODE_TW     = 3'd5,
    CODE_SJIS   = 3'd6,
    CODE_EUCJP  = 3'd7
  } code_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_ESC    = 4'd1,
    PH_DOLLAR = 4'd2,
    PH_DES94  = 4'd3,
    PH_STAR   = 4'd4,
    PH_PLUS   = 4'd5,
    PH_AF8E   = 4'd6,
    PH_AFA1   = 4'd7,
    PH_AFE0   = 4'd8,
    PH_SCAN   = 4'd9
  } phase_t;

  typedef struct packed {
    phase_t phase;
    code_t  code;
    logic   done;
  } state_t;

  localparam logic HEUR_RESET = 1'b1;

  localparam logic [7:0] B_NUL    = 8'd0;
  localparam logic [7:0] B_ESC    = 8'd27;
  localparam logic [7:0] B_DOLLAR = 8'h24;
  localparam logic [7:0] B_LPAREN = 8'h28;
  localparam logic [7:0] B_RPAREN = 8'h29;
  localparam logic [7:0] B_STAR   = 8'h2A;
  localparam logic [7:0] B_PLUS   = 8'h2B;
  localparam logic [7:0] B_AT     = 8'h40;
  localparam logic [7:0] B_A      = 8'h41;
  localparam logic [7:0] B_B      = 8'h42;
  localparam logic [7:0] B_C      = 8'h43;
  localparam logic [7:0] B_D      = 8'h44;
  localparam logic [7:0] B_E      = 8'h45;
  localparam logic [7:0] B_G      = 8'h47;
  localparam logic [7:0] B_H      = 8'h48;
  localparam logic [7:0] B_M      = 8'h4D;
  localparam logic [7:0] B_X      = 8'h58;
  localparam logic [7:0] B_TILDE  = 8'd126;
  localparam logic [7:0] B_128    = 8'd128;
  localparam logic [7:0] B_129    = 8'd129;
  localparam logic [7:0] B_141    = 8'd141;
  localparam logic [7:0] B_142    = 8'd142;
  localparam logic [7:0] B_143    = 8'd143;
  localparam logic [7:0] B_159    = 8'd159;
  localparam logic [7:0] B_160    = 8'd160;
  localparam logic [7:0] B_161    = 8'd161;
  localparam logic [7:0] B_223    = 8'd223;
  localparam logic [7:0] B_224    = 8'd224;
  localparam logic [7:0] B_239    = 8'd239;
  localparam logic [7:0] B_240    = 8'd240;
  localparam logic [7:0] B_252    = 8'd252;
  localparam logic [7:0] B_253    = 8'd253;
  localparam logic [7:0] B_254    = 8'd254;

  function automatic logic in_rng(input logic [7:0] b, input logic [7:0] lo,
                                  input logic [7:0] hi);
    return (b >= lo) && (b <= hi);
  endfunction

endpackage

`default_nettype wire

/* rtl/icd_if.sv */
// Valid/ready channel interfaces for text bytes, results and configuration.
`timescale 1ns / 1ps
`default_nettype none

interface icd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       start_autodetect;
  modport source (output valid, output data_byte, output first_byte,
                  output start_autodetect, input ready);
  modport sink (input valid, input data_byte, input first_byte,
                input start_autodetect, output ready);
endinterface

interface icd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] detected_code;
  logic       decided;
  modport source (output valid, output detected_code, output decided, input ready);
  modport sink (input valid, input detected_code, input decided, output ready);
endinterface

interface icd_cfg_if;
  logic valid;
  logic ready;
  logic japanese_heuristics;
  modport source (output valid, output japanese_heuristics, input ready);
  modport sink (input valid, input japanese_heuristics, output ready);
endinterface

`default_nettype wire

/* rtl/iso2022_charset_detector_unit.sv */
// An accepted input word goes through the input register, then the result register, to its result word on out_ch.
// Throughput: one word per cycle while out_ch is ready; the input register and the result register
// run as a two-stage pipe, and the parse state updates once per byte.
// Reset (rst_n low, synchronous): both stages empty, parse phase idle,
// code not set, not decided, japanese_heuristics set to HEUR_INIT (1 by default).
`timescale 1ns / 1ps
`default_nettype none

module iso2022_charset_detector_unit #(
  parameter logic HEUR_INIT = icd_pkg::HEUR_RESET
) (
  input  wire logic clk,
  input  wire logic rst_n,
  icd_in_if.sink    in_ch,
  icd_out_if.source out_ch,
  icd_cfg_if.sink   cfg_ch
);

  logic            heur_r;
  logic            in_valid_r;
  logic [7:0]      in_byte_r;
  logic            in_first_r;
  logic            in_auto_r;
  icd_pkg::state_t st_r;
  icd_pkg::state_t st_nxt;
  logic            out_valid_r;
  icd_pkg::code_t  out_code_r;
  logic            out_dec_r;
  logic            adv;
  logic            in_take;

  // advance the held word into the result register when it is free
  assign adv     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_take = in_ch.valid && in_ch.ready;

  assign in_ch.ready          = !in_valid_r || adv;
  assign cfg_ch.ready         = 1'b1;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.detected_code = out_code_r;
  assign out_ch.decided       = out_dec_r;

  icd_step u_step (
    .st_i             (st_r),
    .data_byte        (in_byte_r),
    .first_byte       (in_first_r),
    .start_autodetect (in_auto_r),
    .heur             (heur_r),
    .st_o             (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heur_r      <= HEUR_INIT;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r.phase  <= icd_pkg::PH_IDLE;
      st_r.code   <= icd_pkg::CODE_NOTSET;
      st_r.done   <= 1'b0;
    end else begin
      if (cfg_ch.valid) heur_r <= cfg_ch.japanese_heuristics;
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r  <= in_ch.data_byte;
      in_first_r <= in_ch.first_byte;
      in_auto_r  <= in_ch.start_autodetect;
    end
    if (adv) begin
      out_code_r <= st_nxt.code;
      out_dec_r  <= st_nxt.done;
    end
  end

`ifndef SYNTHESIS
  a_hold_decided: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && st_r.done && !in_first_r) |=> (st_r.code == $past(st_r.code)))
    else $error("decided code changed without a new string");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.done |-> (st_r.phase == icd_pkg::PH_IDLE))
    else $error("parse phase pending after decision");

  a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (in_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without a blocked result");

  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (out_code_r == st_r.code && out_dec_r == st_r.done))
    else $error("result word differs from stored state");
`endif

endmodule

`default_nettype wire

/* rtl/icd_step.sv */
// Next-state logic for one text byte: ESC sequence and Japanese range parsing.
`timescale 1ns / 1ps
`default_nettype none

module icd_step (
  input  wire icd_pkg::state_t st_i,
  input  wire logic [7:0]      data_byte,
  input  wire logic            first_byte,
  input  wire logic            start_autodetect,
  input  wire logic            heur,
  output icd_pkg::state_t      st_o
);

  icd_pkg::state_t s;
  icd_pkg::state_t n;
  logic [7:0]      b;
  logic            sjis_lead;

  always_comb begin
    b = data_byte;
    s = st_i;
    if (first_byte) begin
      s.phase = icd_pkg::PH_IDLE;
      s.code  = start_autodetect ? icd_pkg::CODE_AUTO : icd_pkg::CODE_NOTSET;
      s.done  = 1'b0;
    end
    sjis_lead = icd_pkg::in_rng(b, icd_pkg::B_129, icd_pkg::B_141) ||
                icd_pkg::in_rng(b, icd_pkg::B_143, icd_pkg::B_159);
    n = s;
    if (!s.done) begin
      n.phase = icd_pkg::PH_IDLE;
      if (b == icd_pkg::B_NUL) begin
        // string end; a pending half-width lead still counts as Shift-JIS
        n.done = 1'b1;
        if (s.phase == icd_pkg::PH_AFA1) n.code = icd_pkg::CODE_SJIS;
      end else begin
        case (s.phase)
          icd_pkg::PH_ESC: begin
            if (b == icd_pkg::B_DOLLAR) n.phase = icd_pkg::PH_DOLLAR;
          end
          icd_pkg::PH_DOLLAR: begin
            if (b == icd_pkg::B_A) begin
              n.code = icd_pkg::CODE_CN; n.done = 1'b1;
            end else if (b == icd_pkg::B_B || b == icd_pkg::B_AT) begin
              n.code = icd_pkg::CODE_JP; n.done = 1'b1;
            end else if (b == icd_pkg::B_LPAREN || b == icd_pkg::B_RPAREN) begin
              n.phase = icd_pkg::PH_DES94;
            end else if (b == icd_pkg::B_STAR) begin
              n.phase = icd_pkg::PH_STAR;
            end else if (b == icd_pkg::B_PLUS) begin
              n.phase = icd_pkg::PH_PLUS;
            end
          end
          icd_pkg::PH_DES94: begin
            if (b == icd_pkg::B_A || b == icd_pkg::B_E || b == icd_pkg::B_X) begin
              n.code = icd_pkg::CODE_CN; n.done = 1'b1;
            end else if (b == icd_pkg::B_C) begin
              n.code = icd_pkg::CODE_KR; n.done = 1'b1;
            end else if (b == icd_pkg::B_D) begin
              n.code = icd_pkg::CODE_JP; n.done = 1'b1;
            end else if (icd_pkg::in_rng(b, icd_pkg::B_G, icd_pkg::B_M)) begin
              n.code = icd_pkg::CODE_TW; n.done = 1'b1;
            end
          end
          icd_pkg::PH_STAR: begin
            if (b == icd_pkg::B_H || b == icd_pkg::B_X) begin
              n.code = icd_pkg::CODE_CN; n.done = 1'b1;
            end
          end
          icd_pkg::PH_PLUS: begin
            if (icd_pkg::in_rng(b, icd_pkg::B_H, icd_pkg::B_M) || b == icd_pkg::B_X) begin
              n.code = icd_pkg::CODE_CN; n.done = 1'b1;
            end
          end
          icd_pkg::PH_AF8E: begin
            if (icd_pkg::in_rng(b, icd_pkg::B_AT, icd_pkg::B_TILDE) ||
                icd_pkg::in_rng(b, icd_pkg::B_128, icd_pkg::B_160) ||
                icd_pkg::in_rng(b, icd_pkg::B_224, icd_pkg::B_252)) begin
              n.code = icd_pkg::CODE_SJIS; n.done = 1'b1;
            end
          end
          icd_pkg::PH_AFA1: begin
            if (icd_pkg::in_rng(b, icd_pkg::B_240, icd_pkg::B_254)) begin
              n.code = icd_pkg::CODE_EUCJP; n.done = 1'b1;
            end else if (icd_pkg::in_rng(b, icd_pkg::B_224, icd_pkg::B_239)) begin
              n.phase = icd_pkg::PH_SCAN;
            end else if (b <= icd_pkg::B_159) begin
              n.code = icd_pkg::CODE_SJIS; n.done = 1'b1;
            end
          end
          icd_pkg::PH_AFE0: begin
            if (icd_pkg::in_rng(b, icd_pkg::B_AT, icd_pkg::B_TILDE) ||
                icd_pkg::in_rng(b, icd_pkg::B_128, icd_pkg::B_160)) begin
              n.code = icd_pkg::CODE_SJIS; n.done = 1'b1;
            end else if (icd_pkg::in_rng(b, icd_pkg::B_253, icd_pkg::B_254)) begin
              n.code = icd_pkg::CODE_EUCJP; n.done = 1'b1;
            end
          end
          icd_pkg::PH_SCAN: begin
            // stay in the scan until a deciding byte; a byte below '@' drops it
            if (b >= icd_pkg::B_AT) begin
              if (sjis_lead) begin
                n.code = icd_pkg::CODE_SJIS; n.done = 1'b1;
              end else if (icd_pkg::in_rng(b, icd_pkg::B_253, icd_pkg::B_254)) begin
                n.code = icd_pkg::CODE_EUCJP; n.done = 1'b1;
              end else begin
                n.phase = icd_pkg::PH_SCAN;
              end
            end
          end
          default: begin
            if (b == icd_pkg::B_ESC) begin
              n.phase = icd_pkg::PH_ESC;
            end else if (s.code == icd_pkg::CODE_NOTSET) begin
              n.done = 1'b1;
            end else if (heur) begin
              if (sjis_lead) begin
                n.code = icd_pkg::CODE_SJIS; n.done = 1'b1;
              end else if (b == icd_pkg::B_142) begin
                n.phase = icd_pkg::PH_AF8E;
              end else if (icd_pkg::in_rng(b, icd_pkg::B_161, icd_pkg::B_223)) begin
                n.phase = icd_pkg::PH_AFA1;
              end else if (icd_pkg::in_rng(b, icd_pkg::B_240, icd_pkg::B_254)) begin
                n.code = icd_pkg::CODE_EUCJP; n.done = 1'b1;
              end else if (icd_pkg::in_rng(b, icd_pkg::B_224, icd_pkg::B_239)) begin
                n.phase = icd_pkg::PH_AFE0;
              end
            end
          end
        endcase
      end
    end
    st_o = n;
  end

endmodule

`default_nettype wire

/* test/iso2022_charset_detector_unit_test.sv */
// Self-checking testbench for iso2022_charset_detector_unit: directed and random text.
`timescale 1ns / 1ps

module iso2022_charset_detector_unit_test;
  import icd_pkg::*;

  typedef struct {
    code_t code;
    logic  decided;
  } verdict_t;

  typedef logic [7:0] text_t[$];

  logic clk = 1'b0;
  logic rst_n;

  icd_in_if  in_ch ();
  icd_out_if out_ch ();
  icd_cfg_if cfg_ch ();

  iso2022_charset_detector_unit u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #1 clk = ~clk;

  // Detector state as the testbench tracks it
  phase_t cur_phase;
  code_t  cur_code;
  logic   cur_done;
  logic   heur_on;

  verdict_t pending_verdicts[$];

  int mismatches   = 0;
  int results_seen = 0;
  int bytes_sent   = 0;
  int live_bytes   = 0;
  int cfg_writes   = 0;
  int rx_hold      = 0;
  bit tx_gaps      = 1'b1;
  bit rx_stalls    = 1'b1;

  function automatic bit between(input logic [7:0] b, input logic [7:0] lo,
                                 input logic [7:0] hi);
    return (b >= lo) && (b <= hi);
  endfunction

  function automatic void settle_code(input code_t c);
    cur_code  = c;
    cur_done  = 1'b1;
    cur_phase = PH_IDLE;
  endfunction

  function automatic void advance_detector(input logic [7:0] b, input logic first,
                                           input logic autod);
    phase_t ph;
    if (first) begin
      cur_phase = PH_IDLE;
      cur_code  = autod ? CODE_AUTO : CODE_NOTSET;
      cur_done  = 1'b0;
    end
    if (cur_done) return;
    if (b == B_NUL) begin
      // a lead in the upper kana range followed by NUL still counts as Shift-JIS
      if (cur_phase == PH_AFA1) settle_code(CODE_SJIS);
      else settle_code(cur_code);
      return;
    end
    ph = cur_phase;
    cur_phase = PH_IDLE;
    case (ph)
      PH_ESC: begin
        if (b == B_DOLLAR) cur_phase = PH_DOLLAR;
      end
      PH_DOLLAR: begin
        if (b == B_A) settle_code(CODE_CN);
        else if (b == B_B || b == B_AT) settle_code(CODE_JP);
        else if (b == B_LPAREN || b == B_RPAREN) cur_phase = PH_DES94;
        else if (b == B_STAR) cur_phase = PH_STAR;
        else if (b == B_PLUS) cur_phase = PH_PLUS;
      end
      PH_DES94: begin
        if (b == B_A || b == B_E || b == B_X) settle_code(CODE_CN);
        else if (b == B_C) settle_code(CODE_KR);
        else if (b == B_D) settle_code(CODE_JP);
        else if (between(b, B_G, B_M)) settle_code(CODE_TW);
      end
      PH_STAR: begin
        if (b == B_H || b == B_X) settle_code(CODE_CN);
      end
      PH_PLUS: begin
        if (between(b, B_H, B_M) || b == B_X) settle_code(CODE_CN);
      end
      PH_AF8E: begin
        if (between(b, B_AT, B_TILDE) || between(b, B_128, B_160) ||
            between(b, B_224, B_252))
          settle_code(CODE_SJIS);
      end
      PH_AFA1: begin
        if (between(b, B_240, B_254)) settle_code(CODE_EUCJP);
        else if (between(b, B_224, B_239)) cur_phase = PH_SCAN;
        else if (b <= B_159) settle_code(CODE_SJIS);
      end
      PH_AFE0: begin
        if (between(b, B_AT, B_TILDE) || between(b, B_128, B_160)) settle_code(CODE_SJIS);
        else if (between(b, B_253, B_254)) settle_code(CODE_EUCJP);
      end
      PH_SCAN: begin
        // stay in the scan until a deciding byte; anything below '@' drops out
        if (b >= B_AT) begin
          cur_phase = PH_SCAN;
          if (between(b, B_129, B_141) || between(b, B_143, B_159)) settle_code(CODE_SJIS);
          else if (between(b, B_253, B_254)) settle_code(CODE_EUCJP);
        end
      end
      default: begin
        if (b == B_ESC) cur_phase = PH_ESC;
        else if (cur_code == CODE_NOTSET) settle_code(CODE_NOTSET);
        else if (heur_on) begin
          if (between(b, B_129, B_141) || between(b, B_143, B_159)) settle_code(CODE_SJIS);
          else if (b == B_142) cur_phase = PH_AF8E;
          else if (between(b, B_161, B_223)) cur_phase = PH_AFA1;
          else if (between(b, B_240, B_254)) settle_code(CODE_EUCJP);
          else if (between(b, B_224, B_239)) cur_phase = PH_AFE0;
        end
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] jp_byte();
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(129, 141));
      1: return 8'($urandom_range(143, 159));
      2: return B_142;
      3: return 8'($urandom_range(161, 223));
      4: return 8'($urandom_range(224, 239));
      5: return 8'($urandom_range(240, 254));
      6: return 8'($urandom_range(64, 126));
      7: begin
        case ($urandom_range(0, 4))
          0: return B_128;
          1: return B_160;
          2: return B_252;
          3: return B_253;
          default: return 8'hFF;
        endcase
      end
      8: return 8'($urandom_range(1, 63));
      default: return rand_byte();
    endcase
  endfunction

  function automatic void append_token(ref text_t s);
    logic [7:0] second;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        s.push_back(B_ESC);
        s.push_back(($urandom_range(0, 4) != 0) ? B_DOLLAR : rand_byte());
        case ($urandom_range(0, 7))
          0: second = B_A;
          1: second = B_B;
          2: second = B_AT;
          3: second = B_LPAREN;
          4: second = B_RPAREN;
          5: second = B_STAR;
          6: second = B_PLUS;
          default: second = rand_byte();
        endcase
        s.push_back(second);
        if (between(second, B_LPAREN, B_PLUS)) begin
          case ($urandom_range(0, 7))
            0: s.push_back(B_A);
            1: s.push_back(B_E);
            2: s.push_back(B_X);
            3: s.push_back(B_C);
            4: s.push_back(B_D);
            5: s.push_back(8'($urandom_range(B_G, B_M)));
            6: s.push_back(8'($urandom_range(8'h40, 8'h5F)));
            default: s.push_back(rand_byte());
          endcase
        end
      end
      3, 4, 5: begin
        s.push_back(jp_byte());
        s.push_back(jp_byte());
        if ($urandom_range(0, 2) == 0)
          repeat ($urandom_range(1, 5)) s.push_back(jp_byte());
      end
      6: s.push_back(8'($urandom_range(1, 127)));
      7: s.push_back(rand_byte());
      8: s.push_back(B_NUL);
      default: begin
        // terminate, then a trail byte that must be ignored
        s.push_back(B_NUL);
        s.push_back(rand_byte());
      end
    endcase
  endfunction

  task automatic send_text_byte(input logic [7:0] b, input logic first, input logic autod);
    int gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.data_byte        <= b;
    in_ch.first_byte       <= first;
    in_ch.start_autodetect <= autod;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    bytes_sent++;
    if (first || !cur_done) live_bytes++;
    advance_detector(b, first, autod);
    pending_verdicts.push_back('{cur_code, cur_done});
  endtask

  task automatic send_string(input text_t s, input logic autod, input logic restart,
                             input bit mix);
    foreach (s[k]) begin
      if (k == 0) send_text_byte(s[k], restart, autod);
      else if (mix) send_text_byte(s[k], $urandom_range(0, 39) == 0,
                                   1'($urandom_range(0, 1)));
      else send_text_byte(s[k], 1'b0, 1'($urandom_range(0, 1)));
    end
  endtask

  // Drop valid and let the pipe empty out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_heuristics(input logic on);
    wait_drained();
    cfg_ch.valid               <= 1'b1;
    cfg_ch.japanese_heuristics <= on;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    heur_on = on;
    cfg_writes++;
  endtask

  task automatic test_after_reset();
    // no first word yet: behaves as a not-set string; escape still decides
    send_string('{B_ESC, B_DOLLAR, B_A, 8'hFF}, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_escape_designators();
    send_string('{B_ESC, B_DOLLAR, B_LPAREN, B_C}, 1'b1, 1'b1, 1'b0);
    send_string('{8'hFF, B_ESC, B_DOLLAR, B_PLUS, B_X}, 1'b1, 1'b1, 1'b0);
    send_string('{B_A}, 1'b0, 1'b1, 1'b0);
  endtask

  task automatic test_japanese_ranges();
    send_string('{B_142, B_NUL}, 1'b1, 1'b1, 1'b0);
    send_string('{B_161, B_NUL}, 1'b1, 1'b1, 1'b0);
    send_string('{B_161, B_224, 8'd63, B_254}, 1'b1, 1'b1, 1'b0);
    send_string('{B_NUL}, 1'b1, 1'b1, 1'b0);
  endtask

  task automatic test_heuristics_change();
    // a lead already seen completes after the heuristics are switched off
    send_string('{B_161}, 1'b1, 1'b1, 1'b0);
    write_heuristics(1'b0);
    send_string('{B_240}, 1'b1, 1'b0, 1'b0);
    send_string('{8'd133, B_NUL}, 1'b1, 1'b1, 1'b0);
    write_heuristics(1'b1);
  endtask

  task automatic test_random_text(input int budget);
    text_t s;
    int target;
    logic autod;
    target = bytes_sent + budget;
    while (bytes_sent < target) begin
      s = {};
      autod = ($urandom_range(0, 3) != 0);
      tx_gaps   = ($urandom_range(0, 4) != 0);
      rx_stalls = ($urandom_range(0, 4) != 0);
      repeat ($urandom_range(1, 4)) append_token(s);
      send_string(s, autod, $urandom_range(0, 19) != 0, 1'b1);
    end
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
  endtask

  task automatic test_output_backpressure();
    text_t s;
    s = {};
    tx_gaps = 1'b0;
    rx_hold = 150;
    repeat (12) append_token(s);
    send_string(s, 1'b1, 1'b1, 1'b0);
    tx_gaps = 1'b1;
  endtask

  task automatic test_sender_pause();
    text_t s;
    repeat (5) begin
      s = {};
      repeat (3) append_token(s);
      send_string(s, 1'b1, 1'b1, 1'b1);
      wait_drained();
    end
  endtask

  // Result receiver: random stalls, plus a long hold-off when requested
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end else begin
        n = rx_stalls ? pick_gap() : 0;
        if (n > 0) begin
          out_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result word with nothing expected: code %0d decided %0d",
                 $realtime, out_ch.detected_code, out_ch.decided);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_ch.detected_code !== want.code) begin
          $display("%0t: detected_code expected %0d got %0d",
                   $realtime, want.code, out_ch.detected_code);
          mismatches++;
        end
        if (out_ch.decided !== want.decided) begin
          $display("%0t: decided expected %0d got %0d",
                   $realtime, want.decided, out_ch.decided);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("Run did not finish in time, %0d results still expected",
             pending_verdicts.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_n                      <= 1'b0;
    in_ch.valid                <= 1'b0;
    in_ch.data_byte            <= B_NUL;
    in_ch.first_byte           <= 1'b0;
    in_ch.start_autodetect     <= 1'b0;
    cfg_ch.valid               <= 1'b0;
    cfg_ch.japanese_heuristics <= HEUR_RESET;
    heur_on   = HEUR_RESET;
    cur_phase = PH_IDLE;
    cur_code  = CODE_NOTSET;
    cur_done  = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_after_reset();
    test_escape_designators();
    test_japanese_ranges();
    test_heuristics_change();
    test_random_text(250);
    write_heuristics(1'b0);
    test_random_text(150);
    write_heuristics(1'b1);
    test_output_backpressure();
    test_sender_pause();
    test_random_text(250);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Sent %0d bytes (%0d read by the parser), checked %0d results",
             bytes_sent, live_bytes, results_seen);
    $display("Heuristics written %0d times; covered output hold-off and sender pause",
             cfg_writes);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL");
    end
    $finish;
  end

endmodule
